>>> rtl/spdl_pkg.sv
// Shared constants and widths for the servo PD position loop.
`default_nettype none

package spdl_pkg;

    localparam int POT_W     = 10;
    localparam int PULSE_W   = 16;
    localparam int GAIN_W    = 12;
    localparam int DAC_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 1'd1;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 12'd384;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 12'd768;

    localparam logic [PULSE_W-1:0] PULSE_HIGH_LIMIT = 16'd2100;
    localparam logic [PULSE_W-1:0] PULSE_LOW_LIMIT  = 16'd900;

    localparam logic signed [12:0] FB_OFFSET     = 13'sd1536;
    localparam logic signed [12:0] PULSE_SPAN_LO = 13'sd1000;
    localparam logic signed [12:0] ANGLE_OFFSET  = 13'sd450;
    localparam logic signed [14:0] SP_SCALE      = 15'sd9;
    localparam logic [12:0]        RECIP_TEN     = 13'd6554;
    localparam logic [26:0]        SAT_LIMIT     = 27'd156160;
    localparam logic [7:0]         RECIP_FIVE    = 8'd205;
    localparam logic [5:0]         DRIVE_MAX     = 6'd60;
    localparam logic [8:0]         DAC_STEP_X4   = 9'd273;

endpackage

`default_nettype wire

>>> rtl/servo_pd_position_loop.sv
// Servo PD position loop: pulse check, angle maps, PD law, saturation and DAC scaling.
//
// Input items arrive on the slave stream (i_s_tvalid, o_s_tready, i_s_tdata), one per
// control tick, with the pot sample in tdata[9:0] and the pulse width in tdata[25:10].
// Each item yields exactly one result on the master stream (o_m_tvalid, i_m_tready,
// o_m_tdata): DAC code in [11:0], forward run pin in [12], reverse run pin in [13].
// The block is a seven-register pipeline; one item can be accepted in every cycle
// unless a result is stalled. The user must write the gains through i_cfg_wen,
// i_cfg_index and i_cfg_wdata only while idle; the block does not enforce this.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_s_tready drops; it follows i_m_tready, so it is high again in the cycle in which
// the result is taken.
// Reset sets the gains to 1.5 and 3.0, clears the stored error and the last good width
// and empties the pipeline.
`default_nettype none

module servo_pd_position_loop (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wen,
    input  wire logic [spdl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [spdl_pkg::GAIN_W-1:0]     i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // Fields from bit 0: pot_sample[9:0], pulse_width[25:10], zero fill.
    input  wire logic [spdl_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // Fields from bit 0: dac_code[11:0], fwd_run_n[12], rev_run_n[13], zero fill.
    output logic [spdl_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import spdl_pkg::*;

    logic [GAIN_W-1:0]  r_kp;
    logic [GAIN_W-1:0]  r_kd;
    logic [11:0]        r_lgw;
    logic signed [12:0] r_prev;
    logic [6:0]         r_vld;
    logic               w_en;

    logic [PULSE_W-1:0] w_pulse;
    logic [11:0]        n_w;

    logic [POT_W-1:0]   r0_pot;
    logic [11:0]        r0_w;
    logic [11:0]        pot3_c;
    logic signed [12:0] fb_c;
    logic signed [12:0] x_c;
    logic signed [14:0] v_c;
    logic [13:0]        absv_c;
    logic [26:0]        prod_c;

    logic [26:0]        r1_prod;
    logic               r1_vneg;
    logic signed [12:0] r1_fb;
    logic [10:0]        qv_c;
    logic signed [12:0] spq_c;
    logic signed [12:0] sp_c;
    logic signed [12:0] e_c;
    logic signed [13:0] d_c;

    logic signed [12:0] r2_e;
    logic signed [13:0] r2_d;
    logic signed [25:0] p_c;
    logic signed [26:0] q_c;

    logic signed [25:0] r3_p;
    logic signed [26:0] r3_q;
    logic signed [27:0] s_c;
    logic [26:0]        abs_c;

    logic [26:0]        r4_abs;
    logic               r4_neg;
    logic               sat_c;
    logic [16:0]        t_c;
    logic [5:0]         mag_c;

    logic [5:0]         r5_mag;
    logic               r5_neg;
    logic [13:0]        dm_c;

    logic [DAC_W-1:0]   r_dac;
    logic               r_neg;

    assign w_en       = !r_vld[6] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[6];
    assign o_m_tdata  = {2'b00, !r_neg, r_neg, r_dac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= PROP_GAIN_RST;
            r_kd <= DERIV_GAIN_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  r_kp <= i_cfg_wdata;
                CFG_DERIV_GAIN: r_kd <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_pulse = i_s_tdata[POT_W +: PULSE_W];
    always_comb begin
        if (w_pulse >= PULSE_HIGH_LIMIT || w_pulse <= PULSE_LOW_LIMIT) begin
            n_w = r_lgw;
        end else begin
            n_w = w_pulse[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_lgw  <= '0;
            r_prev <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[5:0], i_s_tvalid};
            if (i_s_tvalid) begin
                r_lgw <= n_w;
            end
            if (r_vld[1]) begin
                r_prev <= e_c;
            end
        end
    end

    assign pot3_c = {1'b0, r0_pot, 1'b0} + {2'b00, r0_pot};
    assign fb_c   = $signed({1'b0, pot3_c}) - FB_OFFSET;
    assign x_c    = $signed({1'b0, r0_w}) - PULSE_SPAN_LO;
    assign v_c    = 15'(x_c) * SP_SCALE;
    assign absv_c = v_c[14] ? 14'(-v_c) : 14'(v_c);
    assign prod_c = 27'(absv_c) * 27'(RECIP_TEN);

    assign qv_c  = r1_prod[26:16];
    assign spq_c = r1_vneg ? -$signed({2'b00, qv_c}) : $signed({2'b00, qv_c});
    assign sp_c  = spq_c - ANGLE_OFFSET;
    assign e_c   = sp_c - r1_fb;
    assign d_c   = 14'(e_c) - 14'(r_prev);

    assign p_c = 26'($signed({1'b0, r_kp})) * 26'(r2_e);
    assign q_c = 27'($signed({1'b0, r_kd})) * 27'(r2_d);

    assign s_c   = 28'(r3_p) + 28'(r3_q);
    assign abs_c = s_c[27] ? 27'(-s_c) : 27'(s_c);

    assign sat_c = r4_abs >= SAT_LIMIT;
    assign t_c   = 17'(r4_abs[17:9]) * 17'(RECIP_FIVE);
    assign mag_c = sat_c ? DRIVE_MAX : t_c[15:10];

    assign dm_c = 14'(r5_mag) * 14'(DAC_STEP_X4);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_pot  <= i_s_tdata[POT_W-1:0];
            r0_w    <= n_w;
            r1_prod <= prod_c;
            r1_vneg <= v_c[14];
            r1_fb   <= fb_c;
            r2_e    <= e_c;
            r2_d    <= d_c;
            r3_p    <= p_c;
            r3_q    <= q_c;
            r4_abs  <= abs_c;
            r4_neg  <= s_c[27];
            r5_mag  <= mag_c;
            r5_neg  <= r4_neg;
            r_dac   <= dm_c[13:2];
            r_neg   <= r5_neg;
        end
    end

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output stall");

    a_mag_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r5_mag <= DRIVE_MAX))
        else $error("drive magnitude above limit");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && o_m_tvalid && !i_m_tready) |=> (r_vld[6] && r_vld[5]))
        else $error("pipeline lost an item while stalled");

    a_prev_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[1]) |=> (r_prev == r2_e))
        else $error("stored error not taken from the advancing item");

endmodule

`default_nettype wire
